@@ sv/assert_macros.svh @@
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge out of reset
`define ASSERT_AT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: check failed");
// boolean condition must never be seen out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

@@ sv/rrqg_pkg.sv @@
// shared constants, types and arithmetic helpers of the rotation generator
`timescale 1ns / 1ps
`default_nettype none
package rrqg_pkg;

  // lcg step constants and the folded multi-step forms (all mod 2^32)
  localparam logic [31:0] LCG_MUL  = 32'd747796405;
  localparam logic [31:0] LCG_ADD  = 32'd2891336453;
  localparam logic [31:0] LCG_MUL2 = LCG_MUL * LCG_MUL;
  localparam logic [31:0] LCG_MUL3 = LCG_MUL2 * LCG_MUL;
  localparam logic [31:0] LCG_MUL4 = LCG_MUL3 * LCG_MUL;
  localparam logic [31:0] LCG_ADD2 = LCG_ADD * LCG_MUL + LCG_ADD;
  localparam logic [31:0] LCG_ADD3 = LCG_ADD2 * LCG_MUL + LCG_ADD;
  localparam logic [31:0] LCG_ADD4 = LCG_ADD3 * LCG_MUL + LCG_ADD;
  localparam logic [31:0] HASH_MUL = 32'd277803737;

  localparam int unsigned FRAC_W = 24;
  localparam int unsigned WORD_W = 3 * FRAC_W;

  // trig in q2.30
  localparam logic [30:0] Q30_ONE        = 31'h4000_0000;
  localparam logic [29:0] QUARTER_PI_Q30 = 30'd843314857;

  // reciprocals for exact floor division of values below 2^30
  localparam int unsigned RCP_SH = 36;
  localparam logic [35:0] RCP_42 = 36'((64'd1 << RCP_SH) / 42 + 1);
  localparam logic [35:0] RCP_20 = 36'((64'd1 << RCP_SH) / 20 + 1);
  localparam logic [35:0] RCP_6  = 36'((64'd1 << RCP_SH) / 6 + 1);
  localparam logic [35:0] RCP_56 = 36'((64'd1 << RCP_SH) / 56 + 1);
  localparam logic [35:0] RCP_30 = 36'((64'd1 << RCP_SH) / 30 + 1);
  localparam logic [35:0] RCP_12 = 36'((64'd1 << RCP_SH) / 12 + 1);

  localparam logic [16:0] Q15_POS_MAX = 17'd32767;
  localparam logic [16:0] Q15_NEG_MAX = 17'd32768;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  typedef struct packed {
    logic [17:0] rem;
    logic [16:0] root;
    logic [33:0] src;
  } sqrt_t;

  typedef struct packed {
    logic        neg;
    logic [30:0] mag;
  } trig_t;

  // floor(n / d) for n below 2^30, m the matching reciprocal
  function automatic logic [29:0] div_const(input logic [29:0] n, input logic [35:0] m);
    logic [65:0] p;
    p = {36'd0, n} * {30'd0, m};
    return p[65:36];
  endfunction

  // one restoring square root step, two source bits in, one root bit out
  function automatic sqrt_t sqrt_step(input sqrt_t a);
    sqrt_t       r;
    logic [19:0] cur;
    logic [19:0] tst;
    cur = {a.rem, a.src[33:32]};
    tst = {1'b0, a.root, 2'b01};
    r.src = {a.src[31:0], 2'b00};
    if (cur >= tst) begin
      r.rem  = 18'(cur - tst);
      r.root = {a.root[15:0], 1'b1};
    end else begin
      r.rem  = cur[17:0];
      r.root = {a.root[15:0], 1'b0};
    end
    return r;
  endfunction

  // q16 root times signed q30 trig value, rounded to saturated q1.15
  function automatic logic [15:0] scale_q15(input logic [16:0] s, input trig_t t);
    logic [47:0] p;
    logic [16:0] q;
    p = ({31'd0, s} * {17'd0, t.mag}) + 48'h0000_4000_0000;
    q = p[47:31];
    if (!t.neg) begin
      if (q > Q15_POS_MAX) q = Q15_POS_MAX;
      return q[15:0];
    end
    if (q > Q15_NEG_MAX) q = Q15_NEG_MAX;
    return 16'(17'd0 - q);
  endfunction

endpackage
`default_nettype wire

@@ sv/random_rotation_quaternion_gen_unit.sv @@
// top level: random unit quaternion generator, hash front plus math back
// pipeline: front registers, the queue, 9 math stages, 1 output register
// throughput: one word per cycle unless stalled, set by the fully pipelined hash and math stages
// the back stalls only when its last stage and the output register are both held
// reset (async, active low) empties the pipes, the queue and the output register
`timescale 1ns / 1ps
`default_nettype none
module random_rotation_quaternion_gen_unit #(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // input side: queue-style push/full
  input  wire logic               push,
  output logic                    full,
  input  wire logic [31:0]        frame_number_i,
  // result side: queue-style empty/pop, head word on the ports
  output logic                    empty,
  input  wire logic               pop,
  output logic signed [15:0]      quat_x_o,
  output logic signed [15:0]      quat_y_o,
  output logic signed [15:0]      quat_z_o,
  output logic signed [15:0]      quat_w_o
);
  // queue between the hash front and the math back
  rrqg_pkg::qstat_t                 qstat;
  logic                             qpush, qpop;
  logic [rrqg_pkg::WORD_W-1:0]      qwdata, qrdata;

  // front: lcg and hash, three 24 bit fractions per word
  rrqg_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_o         (full),
    .frame_number_i (frame_number_i),
    .qstat_i        (qstat),
    .qpush_o        (qpush),
    .qdata_o        (qwdata)
  );

  // decoupling queue, lets either side stall on its own
  rrqg_fifo #(
    .Depth (QueueDepth),
    .Width (rrqg_pkg::WORD_W)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (qpush),
    .wdata_i (qwdata),
    .pop_i   (qpop),
    .stat_o  (qstat),
    .rdata_o (qrdata)
  );

  // back: square roots, sine/cosine, scaling and output register
  rrqg_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .qstat_i  (qstat),
    .qdata_i  (qrdata),
    .qpop_o   (qpop),
    .empty_o  (empty),
    .pop_i    (pop),
    .quat_x_o (quat_x_o),
    .quat_y_o (quat_y_o),
    .quat_z_o (quat_z_o),
    .quat_w_o (quat_w_o)
  );
endmodule
`default_nettype wire

@@ sv/rrqg_fifo.sv @@
// small word queue between the hash front and the math back
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module rrqg_fifo #(
  parameter int unsigned Depth = 4,
  parameter int unsigned Width = 72
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             pop_i,
  output rrqg_pkg::qstat_t      stat_o,
  output logic      [Width-1:0] rdata_o
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    if (pop_i)  rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    if (push_i && !pop_i) cnt_d = cnt_q + CntW'(1);
    else if (pop_i && !push_i) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= wdata_i;
  end

  assign rdata_o      = mem_q[rd_q];
  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);

  `ASSERT_AT(a_cnt_range, clk_i, rst_ni, cnt_q <= CntW'(Depth))
  `ASSERT_NEVER(a_push_full, clk_i, rst_ni, push_i && stat_o.full)
  `ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, pop_i && stat_o.empty)
endmodule
`default_nettype wire

@@ sv/rrqg_front.sv @@
// front end: lcg states and output hash, three fractions per frame
`timescale 1ns / 1ps
`default_nettype none
module rrqg_front (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              push_i,
  output logic                                   full_o,
  input  wire logic [31:0]                       frame_number_i,
  input  wire rrqg_pkg::qstat_t                  qstat_i,
  output logic                                   qpush_o,
  output logic [rrqg_pkg::WORD_W-1:0]            qdata_o
);
  logic        en;
  logic        va_q, vb_q;
  logic [31:0] st_d [3];
  logic [31:0] st_q [3];
  logic [31:0] w_d  [3];
  logic [31:0] w_q  [3];
  logic [31:0] wx   [3];

  assign en     = !(vb_q && qstat_i.full);
  assign full_o = !en;

  // states two to four straight from the seed
  assign st_d[0] = frame_number_i * rrqg_pkg::LCG_MUL2 + rrqg_pkg::LCG_ADD2;
  assign st_d[1] = frame_number_i * rrqg_pkg::LCG_MUL3 + rrqg_pkg::LCG_ADD3;
  assign st_d[2] = frame_number_i * rrqg_pkg::LCG_MUL4 + rrqg_pkg::LCG_ADD4;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      w_d[i] = ((st_q[i] >> ({1'b0, st_q[i][31:28]} + 5'd4)) ^ st_q[i])
               * rrqg_pkg::HASH_MUL;
      wx[i]  = (w_q[i] >> 22) ^ w_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en) begin
      va_q <= push_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q <= st_d;
      w_q  <= w_d;
    end
  end

  assign qpush_o = vb_q && en;
  assign qdata_o = {wx[0][23:0], wx[1][23:0], wx[2][23:0]};
endmodule
`default_nettype wire

@@ sv/rrqg_sincos.sv @@
// nine stage sine/cosine of 2*pi*u/2^24 in q2.30, sign and magnitude out
`timescale 1ns / 1ps
`default_nettype none
module rrqg_sincos (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [23:0] u_i,
  output rrqg_pkg::trig_t  sin_o,
  output rrqg_pkg::trig_t  cos_o
);
  localparam logic [30:0] One = rrqg_pkg::Q30_ONE;

  logic [2:0]  oct_q [1:8];
  logic [29:0] x_q   [1:7];
  logic [29:0] x2_q  [2:7];
  logic [29:0] as3_q, ac3_q, as4_q, ac4_q, as5_q, ac5_q;
  logic [29:0] as6_q, ac6_q, as7_q, ac7_q, s8_q, pc8_q;
  rrqg_pkg::trig_t sin_q, cos_q;

  logic [21:0] rr;
  logic [51:0] px;
  logic [59:0] p2;
  logic [60:0] ps4, pc4, ps6, pc6, ps8, pc8;
  logic [30:0] c9, s9;
  logic [30:0] sa, ca;
  rrqg_pkg::trig_t sn, cs;

  always_comb begin
    rr  = u_i[21] ? (22'h20_0000 - {1'b0, u_i[20:0]}) : {1'b0, u_i[20:0]};
    px  = {30'd0, rr} * {22'd0, rrqg_pkg::QUARTER_PI_Q30};
    p2  = {30'd0, x_q[1]} * {30'd0, x_q[1]};
    ps4 = {31'd0, x2_q[3]} * (One - {1'b0, as3_q});
    pc4 = {31'd0, x2_q[3]} * (One - {1'b0, ac3_q});
    ps6 = {31'd0, x2_q[5]} * (One - {1'b0, as5_q});
    pc6 = {31'd0, x2_q[5]} * (One - {1'b0, ac5_q});
    ps8 = {31'd0, x_q[7]}  * (One - {1'b0, as7_q});
    pc8 = {31'd0, x2_q[7]} * (One - {1'b0, ac7_q});
    s9  = {1'b0, s8_q};
    c9  = One - {2'b00, pc8_q[29:1]};
    // odd octants mirror the angle, so sine and cosine swap
    sa  = oct_q[8][0] ? c9 : s9;
    ca  = oct_q[8][0] ? s9 : c9;
    case (oct_q[8][2:1])
      2'd0: begin
        sn = '{neg: 1'b0, mag: sa};
        cs = '{neg: 1'b0, mag: ca};
      end
      2'd1: begin
        sn = '{neg: 1'b0, mag: ca};
        cs = '{neg: 1'b1, mag: sa};
      end
      2'd2: begin
        sn = '{neg: 1'b1, mag: sa};
        cs = '{neg: 1'b1, mag: ca};
      end
      default: begin
        sn = '{neg: 1'b1, mag: ca};
        cs = '{neg: 1'b0, mag: sa};
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      oct_q[1] <= u_i[23:21];
      x_q[1]   <= px[50:21];
      for (int k = 2; k <= 8; k++) oct_q[k] <= oct_q[k-1];
      for (int k = 2; k <= 7; k++) x_q[k] <= x_q[k-1];
      x2_q[2] <= p2[59:30];
      for (int k = 3; k <= 7; k++) x2_q[k] <= x2_q[k-1];
      as3_q <= rrqg_pkg::div_const(x2_q[2], rrqg_pkg::RCP_42);
      ac3_q <= rrqg_pkg::div_const(x2_q[2], rrqg_pkg::RCP_56);
      as4_q <= ps4[59:30];
      ac4_q <= pc4[59:30];
      as5_q <= rrqg_pkg::div_const(as4_q, rrqg_pkg::RCP_20);
      ac5_q <= rrqg_pkg::div_const(ac4_q, rrqg_pkg::RCP_30);
      as6_q <= ps6[59:30];
      ac6_q <= pc6[59:30];
      as7_q <= rrqg_pkg::div_const(as6_q, rrqg_pkg::RCP_6);
      ac7_q <= rrqg_pkg::div_const(ac6_q, rrqg_pkg::RCP_12);
      s8_q  <= ps8[59:30];
      pc8_q <= pc8[59:30];
      sin_q <= sn;
      cos_q <= cs;
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;
endmodule
`default_nettype wire

@@ sv/rrqg_back.sv @@
// back end: two square roots, two sine/cosine pipes and the q1.15 scaling
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module rrqg_back (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire rrqg_pkg::qstat_t                 qstat_i,
  input  wire logic [rrqg_pkg::WORD_W-1:0]      qdata_i,
  output logic                                  qpop_o,
  output logic                                  empty_o,
  input  wire logic                             pop_i,
  output logic signed [15:0]                    quat_x_o,
  output logic signed [15:0]                    quat_y_o,
  output logic signed [15:0]                    quat_z_o,
  output logic signed [15:0]                    quat_w_o
);
  localparam int unsigned Stages = 9;

  logic               en;
  logic [Stages:1]    v_q;
  logic               out_valid_q;
  logic               load;
  logic [23:0]        u0, u1, u2;
  logic [24:0]        one_minus;
  rrqg_pkg::sqrt_t    sa_init, sb_init;
  rrqg_pkg::sqrt_t    sa_q [1:Stages];
  rrqg_pkg::sqrt_t    sb_q [1:Stages];
  rrqg_pkg::trig_t    sin1, cos1, sin2, cos2;
  logic [15:0]        x_q, y_q, z_q, w_q;

  assign {u0, u1, u2} = qdata_i;
  assign en     = !(v_q[Stages] && out_valid_q && !pop_i);
  assign qpop_o = en && !qstat_i.empty;
  assign load   = v_q[Stages] && en;

  assign one_minus = 25'h100_0000 - {1'b0, u0};
  assign sa_init   = '{rem: '0, root: '0, src: {1'b0, one_minus, 8'd0}};
  assign sb_init   = '{rem: '0, root: '0, src: {2'b00, u0, 8'd0}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (en) v_q <= {v_q[Stages-1:1], qpop_o};
      if (load) out_valid_q <= 1'b1;
      else if (pop_i) out_valid_q <= 1'b0;
    end
  end

  // root bits: one in the first stage, two in each later one
  always_ff @(posedge clk_i) begin
    if (en) begin
      sa_q[1] <= rrqg_pkg::sqrt_step(sa_init);
      sb_q[1] <= rrqg_pkg::sqrt_step(sb_init);
      for (int k = 2; k <= Stages; k++) begin
        sa_q[k] <= rrqg_pkg::sqrt_step(rrqg_pkg::sqrt_step(sa_q[k-1]));
        sb_q[k] <= rrqg_pkg::sqrt_step(rrqg_pkg::sqrt_step(sb_q[k-1]));
      end
    end
    if (load) begin
      x_q <= rrqg_pkg::scale_q15(sa_q[Stages].root, sin1);
      y_q <= rrqg_pkg::scale_q15(sa_q[Stages].root, cos1);
      z_q <= rrqg_pkg::scale_q15(sb_q[Stages].root, sin2);
      w_q <= rrqg_pkg::scale_q15(sb_q[Stages].root, cos2);
    end
  end

  rrqg_sincos u_trig1 (
    .clk_i (clk_i),
    .en_i  (en),
    .u_i   (u1),
    .sin_o (sin1),
    .cos_o (cos1)
  );

  rrqg_sincos u_trig2 (
    .clk_i (clk_i),
    .en_i  (en),
    .u_i   (u2),
    .sin_o (sin2),
    .cos_o (cos2)
  );

  assign empty_o  = !out_valid_q;
  assign quat_x_o = x_q;
  assign quat_y_o = y_q;
  assign quat_z_o = z_q;
  assign quat_w_o = w_q;

  `ASSERT_AT(a_stall_hold, clk_i, rst_ni, (v_q[Stages] && !en) |=> v_q[Stages])
endmodule
`default_nettype wire

@@ verif/rrqg_checker.sv @@
// checker: predicts each quaternion word from the frame number and compares
`timescale 1ns / 1ps
`default_nettype none
module rrqg_checker (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  input  wire logic               full,
  input  wire logic [31:0]        frame_number_i,
  input  wire logic               empty,
  input  wire logic               pop,
  input  wire logic signed [15:0] quat_x_o,
  input  wire logic signed [15:0] quat_y_o,
  input  wire logic signed [15:0] quat_z_o,
  input  wire logic signed [15:0] quat_w_o,
  output int                      fail_count_o,
  output int                      pending_o,
  output int                      seen_o
);

  localparam logic [31:0] STEP_MUL  = 32'd747796405;
  localparam logic [31:0] STEP_ADD  = 32'd2891336453;
  localparam logic [31:0] MIX_MUL   = 32'd277803737;
  localparam longint      ONE_Q30   = 64'd1073741824;
  localparam longint      PI4_Q30   = 64'd843314857;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic [15:0] w;
  } quat_t;

  quat_t expected_quats[$];

  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // sine and cosine of 2*pi*u/2^24 in q2.30
  function automatic void angle_trig(input logic [23:0] u, output longint sn,
                                     output longint cs);
    logic [2:0]      oct;
    longint unsigned r, x, x2, t, s, c;
    longint          sa, ca;
    oct = u[23:21];
    r = u[20:0];
    if (oct[0]) r = (64'd1 << 21) - r;
    x = (r * PI4_Q30) >> 21;
    x2 = (x * x) >> 30;
    t = ONE_Q30 - x2 / 42;
    t = ONE_Q30 - ((x2 * t) >> 30) / 20;
    t = ONE_Q30 - ((x2 * t) >> 30) / 6;
    s = (x * t) >> 30;
    t = ONE_Q30 - x2 / 56;
    t = ONE_Q30 - ((x2 * t) >> 30) / 30;
    t = ONE_Q30 - ((x2 * t) >> 30) / 12;
    c = ONE_Q30 - ((x2 * t) >> 30) / 2;
    sa = oct[0] ? c : s;
    ca = oct[0] ? s : c;
    case (oct[2:1])
      2'd0: begin sn = sa;  cs = ca;  end
      2'd1: begin sn = ca;  cs = -sa; end
      2'd2: begin sn = -sa; cs = -ca; end
      default: begin sn = -ca; cs = sa; end
    endcase
  endfunction

  function automatic logic [15:0] to_q15(input longint unsigned s, input longint tr);
    longint unsigned m, q;
    m = (tr < 0) ? -tr : tr;
    q = (s * m + (64'd1 << 30)) >> 31;
    if (tr >= 0) return (q > 32767) ? 16'd32767 : q[15:0];
    if (q > 32768) q = 32768;
    return 16'(-q);
  endfunction

  function automatic quat_t predict_quat(input logic [31:0] frame);
    logic [31:0]     st, h;
    logic [23:0]     frac[3];
    longint unsigned r1, r2;
    longint          sa, ca, sb, cb;
    quat_t           q;
    st = frame * STEP_MUL + STEP_ADD;
    for (int i = 0; i < 3; i++) begin
      st = st * STEP_MUL + STEP_ADD;
      h = ((st >> ((st >> 28) + 4)) ^ st) * MIX_MUL;
      h = (h >> 22) ^ h;
      frac[i] = h[23:0];
    end
    r1 = root_floor(((64'd1 << 24) - frac[0]) << 8);
    r2 = root_floor(64'(frac[0]) << 8);
    angle_trig(frac[1], sa, ca);
    angle_trig(frac[2], sb, cb);
    q.x = to_q15(r1, sa);
    q.y = to_q15(r1, ca);
    q.z = to_q15(r2, sb);
    q.w = to_q15(r2, cb);
    return q;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, $signed(got),
             $signed(want), $realtime);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    seen_o = 0;
  end
  assign pending_o = expected_quats.size();

  always @(posedge clk_i) begin
    quat_t q;
    if (rst_ni) begin
      if (push && !full) expected_quats.push_back(predict_quat(frame_number_i));
      if (pop && !empty) begin
        seen_o++;
        if (expected_quats.size() == 0) begin
          $display("unexpected word at %0t", $realtime);
          fail_count_o++;
        end else begin
          q = expected_quats.pop_front();
          if (quat_x_o !== q.x) report_mismatch("quat_x", quat_x_o, q.x);
          if (quat_y_o !== q.y) report_mismatch("quat_y", quat_y_o, q.y);
          if (quat_z_o !== q.z) report_mismatch("quat_z", quat_z_o, q.z);
          if (quat_w_o !== q.w) report_mismatch("quat_w", quat_w_o, q.w);
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ verif/tb_random_rotation_quaternion_gen_unit.sv @@
// testbench top: drives frame numbers, pops quaternion words, gives the verdict
`timescale 1ns / 1ps
`default_nettype none
module tb_random_rotation_quaternion_gen_unit;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               push = 1'b0;
  logic               full;
  logic [31:0]        frame_number_i = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic signed [15:0] quat_x_o, quat_y_o, quat_z_o, quat_w_o;
  int                 fail_count, pending, seen;
  int                 frames_sent;

  always #2 clk_i = ~clk_i;

  random_rotation_quaternion_gen_unit u_dut (
    .clk_i, .rst_ni, .push, .full, .frame_number_i,
    .empty, .pop, .quat_x_o, .quat_y_o, .quat_z_o, .quat_w_o
  );

  rrqg_checker u_checker (
    .clk_i, .rst_ni, .push, .full, .frame_number_i,
    .empty, .pop, .quat_x_o, .quat_y_o, .quat_z_o, .quat_w_o,
    .fail_count_o(fail_count), .pending_o(pending), .seen_o(seen)
  );

  // gap length: mostly zero or short, now and then long
  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // hold push high until the word is taken; push stays up between back-to-back words
  task automatic send_frame(input logic [31:0] f);
    frame_number_i <= f;
    push <= 1'b1;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    frames_sent++;
  endtask

  task automatic idle_sender(input int n);
    if (n > 0) begin
      push <= 1'b0;
      frame_number_i <= $urandom;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // receiver: random pop pattern, with a burst of always-ready stretches
  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ($urandom_range(9) < 3) begin
        pop <= 1'b1;
        repeat ($urandom_range(60, 10)) @(posedge clk_i);
      end
      g = gap_len();
      if (g == 0) begin
        pop <= 1'b1;
      end else begin
        pop <= 1'b0;
        repeat (g) @(posedge clk_i);
        pop <= 1'b1;
      end
    end
  end

  initial begin
    logic [31:0] directed[$];
    frames_sent = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // field extremes, all ones, bits 0 and 31 and every third single bit from bit 1
    directed = '{32'h0, 32'hFFFF_FFFF, 32'h1, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_FFFF, 32'hFFFF_0000};
    foreach (directed[i]) send_frame(directed[i]);
    for (int b = 1; b < 31; b += 3) send_frame(32'h1 << b);
    idle_sender(1);

    // a pause until the pipe has fully drained
    while (pending != 0) @(posedge clk_i);

    // random frames, contiguous runs like a frame counter, and plain noise
    for (int n = 0; n < 1000; ) begin
      logic [31:0] base;
      int          run;
      base = $urandom;
      run = $urandom_range(8, 1);
      for (int k = 0; k < run; k++) begin
        send_frame(($urandom_range(3) == 0) ? base + k : $urandom);
        idle_sender(gap_len());
        n++;
      end
    end
    push <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("sent %0d frame numbers (directed extremes, counter runs, random), %0d checked",
             frames_sent, seen);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
`default_nettype wire
